[src/joystick_differential_drive_mixer_top_macros.svh]
// ----------------------------------------------------------------------------
// joystick differential drive mixer: assertion macros
// concurrent assertion helpers shared by the checker files
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_TOP_MACROS_SVH
`define JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define JDDM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define JDDM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/jddm_pkg.sv]
// ----------------------------------------------------------------------------
// jddm_pkg
// shared constants, types and tables of the joystick drive mixer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jddm_pkg;

  // vectoring iterations, capped at the length of the angle table
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_N     = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

  // raw reading that maps to full deflection
  localparam int FULL_SCALE = 13000;

  // normalisation by reciprocal multiply: q = floor((mag*65536 + FS) / (2*FS))
  localparam int SCALE_W     = $clog2(FULL_SCALE + 1);
  localparam int NORM_DIV    = 2 * FULL_SCALE;
  localparam int NUM_W       = SCALE_W + 17;
  localparam longint unsigned NORM_RECIP_FULL = (64'd1 << 32) / 64'(NORM_DIV);
  localparam int RECIP_W     = $clog2(NORM_RECIP_FULL + 1);
  localparam int NORM_PROD_W = NUM_W + RECIP_W;
  localparam int REM_W       = $clog2(2 * NORM_DIV);
  localparam logic [RECIP_W-1:0] NORM_RECIP = RECIP_W'(NORM_RECIP_FULL);

  // axis magnitudes run 0..32768
  localparam int Q_W   = 15;
  localparam int MAG_W = 16;
  localparam logic [MAG_W-1:0] AXIS_FULL = 16'd32768;

  // vectoring datapath widths
  localparam int CX_W = 26;
  localparam int Z_W  = 19;
  localparam logic [16:0] UNIT_Q16  = 17'd65536;
  localparam logic [15:0] INV_GAIN  = 16'd39797;

  // configuration port
  localparam int CFG_W      = 15;
  localparam int CFG_ADDR_W = 3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_FORWARD_CENTER   = 3'd0,
    CFG_SIDEWAYS_CENTER  = 3'd1,
    CFG_DEADZONE         = 3'd2,
    CFG_EQUALIZE         = 3'd3,
    CFG_REVERSE_SIDEWAYS = 3'd4
  } cfg_reg_e;

  // how the back end turns an item into wheel values
  typedef enum logic [1:0] {
    KIND_MIX,
    KIND_PIVOT,
    KIND_REVERSE
  } kind_e;

  // classified item held in the queue
  typedef struct packed {
    kind_e            kind;
    logic             neg;         // wheels run backwards
    logic             inner_left;  // left wheel takes the inner value
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // atan(2^-i) as a fraction of a quarter turn, Q16
  function automatic logic [16:0] atan_q16(input logic [4:0] idx);
    logic [16:0] v;
    unique case (idx)
      5'd0:    v = 17'd32768;
      5'd1:    v = 17'd19344;
      5'd2:    v = 17'd10221;
      5'd3:    v = 17'd5188;
      5'd4:    v = 17'd2604;
      5'd5:    v = 17'd1303;
      5'd6:    v = 17'd652;
      5'd7:    v = 17'd326;
      5'd8:    v = 17'd163;
      5'd9:    v = 17'd81;
      5'd10:   v = 17'd41;
      5'd11:   v = 17'd20;
      5'd12:   v = 17'd10;
      5'd13:   v = 17'd5;
      5'd14:   v = 17'd3;
      5'd15:   v = 17'd1;
      5'd16:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

endpackage

[src/jddm_front.sv]
// ----------------------------------------------------------------------------
// jddm_front
// centres and normalises both axes, then classifies the stick position
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jddm_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [15:0]      forward_sample_i,
  input  logic signed [15:0]      sideways_sample_i,
  input  logic [14:0]             forward_center_i,
  input  logic [14:0]             sideways_center_i,
  input  logic [6:0]              reverse_sideways_percent_i,
  input  jddm_pkg::q_status_t     q_status_i,
  output logic                    push_o,
  output jddm_pkg::item_t         item_o
);

  // index 0 is the forward axis (y), index 1 the sideways axis (x)
  logic signed [15:0] sample [2];
  logic [14:0]        center [2];

  logic [4:0] vld_q;
  logic       adv;

  logic [16:0]                       diff   [2];
  logic [16:0]                       mag_abs[2];
  logic [jddm_pkg::NUM_W-1:0]        num_d  [2];
  logic [jddm_pkg::NORM_PROD_W-1:0]  prod_d [2];
  logic [jddm_pkg::NUM_W-1:0]        rem_d  [2];
  logic [jddm_pkg::MAG_W-1:0]        q_d    [2];

  logic [jddm_pkg::SCALE_W-1:0] s1_mag_q [2];
  logic [1:0]                   s1_neg_q, s1_sat_q;
  logic [jddm_pkg::NUM_W-1:0]   s2_num_q [2];
  logic [jddm_pkg::Q_W-1:0]     s2_qest_q[2];
  logic [1:0]                   s2_neg_q, s2_sat_q;
  logic [jddm_pkg::Q_W-1:0]     s3_qest_q[2];
  logic [jddm_pkg::REM_W-1:0]   s3_rem_q [2];
  logic [1:0]                   s3_neg_q, s3_sat_q;
  logic [jddm_pkg::MAG_W-1:0]   s4_mag_q [2];
  logic [1:0]                   s4_neg_q;
  jddm_pkg::item_t              s5_item_q;

  logic                 x_ne0, x_lt0, y_lt0, y_le0, rev;
  logic [22:0]          ax_scaled;
  jddm_pkg::item_t      item_d;

  assign sample[0] = forward_sample_i;
  assign sample[1] = sideways_sample_i;
  assign center[0] = forward_center_i;
  assign center[1] = sideways_center_i;

  // the whole front moves unless its last item cannot enter the queue
  assign adv        = !(vld_q[4] && q_status_i.full);
  assign in_stall_o = vld_q[4] && q_status_i.full;
  assign push_o     = vld_q[4] && !q_status_i.full;
  assign item_o     = s5_item_q;

  // per-axis arithmetic
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      diff[a]    = 17'(sample[a]) - 17'(center[a]);
      mag_abs[a] = diff[a][16] ? (~diff[a] + 17'd1) : diff[a];
      num_d[a]   = jddm_pkg::NUM_W'({s1_mag_q[a], 16'b0})
                 + jddm_pkg::NUM_W'(jddm_pkg::FULL_SCALE);
      prod_d[a]  = jddm_pkg::NORM_PROD_W'(num_d[a])
                 * jddm_pkg::NORM_PROD_W'(jddm_pkg::NORM_RECIP);
      rem_d[a]   = s2_num_q[a] - jddm_pkg::NUM_W'(s2_qest_q[a])
                 * jddm_pkg::NUM_W'(jddm_pkg::NORM_DIV);
      q_d[a]     = jddm_pkg::MAG_W'(s3_qest_q[a])
                 + jddm_pkg::MAG_W'(s3_rem_q[a] >= jddm_pkg::REM_W'(jddm_pkg::NORM_DIV));
    end
  end

  // classification of the normalised position
  always_comb begin
    x_ne0     = (s4_mag_q[1] != '0);
    x_lt0     = s4_neg_q[1];
    y_lt0     = s4_neg_q[0];
    y_le0     = s4_neg_q[0] || (s4_mag_q[0] == '0);
    ax_scaled = 23'(s4_mag_q[1]) * 23'd100;
    rev       = (ax_scaled < 23'({reverse_sideways_percent_i, 15'b0})) && y_lt0;

    item_d.ax         = s4_mag_q[1];
    item_d.ay         = s4_mag_q[0];
    item_d.inner_left = !x_lt0;
    item_d.neg        = y_lt0 && (rev || !x_ne0);
    priority if (rev) begin
      item_d.kind = jddm_pkg::KIND_REVERSE;
    end else if (x_ne0 && y_le0) begin
      item_d.kind = jddm_pkg::KIND_PIVOT;
    end else begin
      item_d.kind = jddm_pkg::KIND_MIX;
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[3:0], in_valid_i};
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 2; a++) begin
        s1_mag_q[a]  <= mag_abs[a][jddm_pkg::SCALE_W-1:0];
        s2_num_q[a]  <= num_d[a];
        s2_qest_q[a] <= prod_d[a][32 +: jddm_pkg::Q_W];
        s3_qest_q[a] <= s2_qest_q[a];
        s3_rem_q[a]  <= rem_d[a][jddm_pkg::REM_W-1:0];
        s4_mag_q[a]  <= s3_sat_q[a] ? jddm_pkg::AXIS_FULL : q_d[a];
        s4_neg_q[a]  <= s3_neg_q[a];
        s1_neg_q[a]  <= diff[a][16];
        s1_sat_q[a]  <= mag_abs[a] >= 17'(jddm_pkg::FULL_SCALE);
      end
      s2_neg_q  <= s1_neg_q;
      s2_sat_q  <= s1_sat_q;
      s3_neg_q  <= s2_neg_q;
      s3_sat_q  <= s2_sat_q;
      s5_item_q <= item_d;
    end
  end

endmodule

[src/jddm_queue.sv]
// ----------------------------------------------------------------------------
// jddm_queue
// short queue of classified items between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jddm_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  jddm_pkg::item_t     item_i,
  input  logic                pop_i,
  output jddm_pkg::item_t     item_o,
  output jddm_pkg::q_status_t status_o
);

  jddm_pkg::item_t                mem_q [jddm_pkg::QUEUE_DEPTH];
  logic [jddm_pkg::QUEUE_AW-1:0]  wptr_q, rptr_q;
  logic [jddm_pkg::QUEUE_AW:0]    cnt_q;

  assign status_o.full  = (cnt_q == (jddm_pkg::QUEUE_AW+1)'(jddm_pkg::QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign item_o         = mem_q[rptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule

[src/jddm_cordic.sv]
// ----------------------------------------------------------------------------
// jddm_cordic
// pipelined vectoring rotator, one iteration per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jddm_cordic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  jddm_pkg::item_t                     item_i,
  output logic                                valid_o,
  output jddm_pkg::item_t                     item_o,
  output logic signed [jddm_pkg::CX_W-1:0]    cx_o,
  output logic signed [jddm_pkg::Z_W-1:0]     z_o
);

  localparam int N = jddm_pkg::CORDIC_N;

  logic signed [jddm_pkg::CX_W-1:0] cx_q [N];
  logic signed [jddm_pkg::CX_W-1:0] cy_q [N];
  logic signed [jddm_pkg::Z_W-1:0]  z_q  [N];
  jddm_pkg::item_t                  item_q [N];
  logic [N-1:0]                     vld_q;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [jddm_pkg::CX_W-1:0] cx_in, cy_in, dx, dy;
    logic signed [jddm_pkg::Z_W-1:0]  z_in, ang;
    jddm_pkg::item_t                  it_in;
    logic                             v_in;

    // x starts as |y| and y as |x|, both scaled by 256
    if (i == 0) begin : g_first
      assign cx_in = $signed(jddm_pkg::CX_W'({item_i.ay, 8'b0}));
      assign cy_in = $signed(jddm_pkg::CX_W'({item_i.ax, 8'b0}));
      assign z_in  = '0;
      assign it_in = item_i;
      assign v_in  = valid_i;
    end else begin : g_next
      assign cx_in = cx_q[i-1];
      assign cy_in = cy_q[i-1];
      assign z_in  = z_q[i-1];
      assign it_in = item_q[i-1];
      assign v_in  = vld_q[i-1];
    end

    assign dx  = cy_in >>> i;
    assign dy  = cx_in >>> i;
    assign ang = $signed(jddm_pkg::Z_W'(jddm_pkg::atan_q16(5'(i))));

    // stage valid
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= v_in;
      end
    end

    // rotate towards the x axis
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!cy_in[jddm_pkg::CX_W-1]) begin
          cx_q[i] <= cx_in + dx;
          cy_q[i] <= cy_in - dy;
          z_q[i]  <= z_in + ang;
        end else begin
          cx_q[i] <= cx_in - dx;
          cy_q[i] <= cy_in + dy;
          z_q[i]  <= z_in - ang;
        end
        item_q[i] <= it_in;
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign item_o  = item_q[N-1];
  assign cx_o    = cx_q[N-1];
  assign z_o     = z_q[N-1];

endmodule

[src/jddm_back.sv]
// ----------------------------------------------------------------------------
// jddm_back
// wheel mixing, deadzone, equalising and percent rounding with output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jddm_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  jddm_pkg::item_t                   item_i,
  input  logic signed [jddm_pkg::CX_W-1:0]  cx_i,
  input  logic signed [jddm_pkg::Z_W-1:0]   z_i,
  input  logic [6:0]                        deadzone_percent_i,
  input  logic [7:0]                        equalize_percent_i,
  output logic                              adv_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [7:0]                 left_speed_o,
  output logic signed [7:0]                 right_speed_o
);

  logic [5:0] vld_q;

  // stage 1: clamp and gain product
  logic [16:0]                    zc_d;
  logic [jddm_pkg::CX_W-2:0]      cxc_d;
  logic [40:0]                    b1_prod_q;
  logic [16:0]                    b1_z_q;
  jddm_pkg::item_t                b1_item_q;

  // stage 2: magnitude and inner factor
  logic [40:0]                    mag_sum;
  logic [16:0]                    mag_r;
  logic [15:0]                    b2_mag_q;
  logic [16:0]                    b2_inner_q;
  jddm_pkg::item_t                b2_item_q;

  // stage 3: wheel magnitudes
  logic [31:0]                    inner_v, outer_v, rev_v, lm_d, rm_d;
  logic [31:0]                    b3_lm_q, b3_rm_q;
  logic                           b3_neg_q;

  // stage 4: deadzone test and difference
  logic [38:0]                    l100, r100, dz_lim;
  logic [31:0]                    b4_lm_q, b4_rm_q, b4_diff_q;
  logic                           b4_neg_q, b4_dz_q, b4_lge_q;

  // stage 5: equalising
  logic                           eq_hit;
  logic [31:0]                    lm5_d, rm5_d;
  logic [31:0]                    b5_lm_q, b5_rm_q;
  logic                           b5_neg_q;

  // stage 6: percent rounding
  logic [38:0]                    lp_sum, rp_sum;
  logic [7:0]                     lp, rp;
  logic signed [7:0]              left_q, right_q;

  // the back pipeline stops as a whole while a result waits
  assign adv_o         = !(vld_q[5] && out_stall_i);
  assign out_valid_o   = vld_q[5];
  assign left_speed_o  = left_q;
  assign right_speed_o = right_q;

  always_comb begin
    // angle saturated to a quarter turn, x never negative
    if (z_i[jddm_pkg::Z_W-1]) begin
      zc_d = '0;
    end else if ($unsigned(z_i) > jddm_pkg::Z_W'(jddm_pkg::UNIT_Q16)) begin
      zc_d = jddm_pkg::UNIT_Q16;
    end else begin
      zc_d = z_i[16:0];
    end
    cxc_d = cx_i[jddm_pkg::CX_W-1] ? '0 : cx_i[jddm_pkg::CX_W-2:0];

    // magnitude rounded and saturated at full deflection
    mag_sum = b1_prod_q + 41'(24'h800000);
    mag_r   = mag_sum[40:24];

    // wheel magnitudes by item kind
    inner_v = 32'(b2_mag_q) * 32'(b2_inner_q);
    outer_v = {b2_mag_q, 16'b0};
    rev_v   = {b2_item_q.ay, 16'b0};
    unique case (b2_item_q.kind)
      jddm_pkg::KIND_REVERSE: begin
        lm_d = rev_v;
        rm_d = rev_v;
      end
      jddm_pkg::KIND_MIX, jddm_pkg::KIND_PIVOT: begin
        lm_d = b2_item_q.inner_left ? inner_v : outer_v;
        rm_d = b2_item_q.inner_left ? outer_v : inner_v;
      end
      default: begin
        lm_d = '0;
        rm_d = '0;
      end
    endcase

    // deadzone on both wheels
    l100   = 39'(b3_lm_q) * 39'd100;
    r100   = 39'(b3_rm_q) * 39'd100;
    dz_lim = 39'({deadzone_percent_i, 31'b0});

    // equalise close speeds that share a sign
    eq_hit = (40'(b4_diff_q) * 40'd100) < 40'({equalize_percent_i, 31'b0});
    priority if (b4_dz_q) begin
      lm5_d = '0;
      rm5_d = '0;
    end else if (eq_hit && (b4_lm_q != '0) && (b4_rm_q != '0)) begin
      lm5_d = b4_lge_q ? b4_lm_q : b4_rm_q;
      rm5_d = b4_lge_q ? b4_lm_q : b4_rm_q;
    end else begin
      lm5_d = b4_lm_q;
      rm5_d = b4_rm_q;
    end

    // round to whole percent
    lp_sum = 39'(b5_lm_q) * 39'd100 + 39'(31'h40000000);
    rp_sum = 39'(b5_rm_q) * 39'd100 + 39'(31'h40000000);
    lp     = lp_sum[38:31];
    rp     = rp_sum[38:31];
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_o) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      b1_prod_q  <= 41'(cxc_d) * 41'(jddm_pkg::INV_GAIN);
      b1_z_q     <= zc_d;
      b1_item_q  <= item_i;

      b2_mag_q   <= (mag_r > 17'(jddm_pkg::AXIS_FULL)) ? jddm_pkg::AXIS_FULL : mag_r[15:0];
      b2_inner_q <= (b1_item_q.kind == jddm_pkg::KIND_PIVOT) ? 17'd0
                                                              : jddm_pkg::UNIT_Q16 - b1_z_q;
      b2_item_q  <= b1_item_q;

      b3_lm_q    <= lm_d;
      b3_rm_q    <= rm_d;
      b3_neg_q   <= b2_item_q.neg;

      b4_lm_q    <= b3_lm_q;
      b4_rm_q    <= b3_rm_q;
      b4_neg_q   <= b3_neg_q;
      b4_dz_q    <= (l100 < dz_lim) && (r100 < dz_lim);
      b4_lge_q   <= b3_lm_q >= b3_rm_q;
      b4_diff_q  <= (b3_lm_q >= b3_rm_q) ? (b3_lm_q - b3_rm_q) : (b3_rm_q - b3_lm_q);

      b5_lm_q    <= lm5_d;
      b5_rm_q    <= rm5_d;
      b5_neg_q   <= b4_neg_q;

      left_q     <= b5_neg_q ? -$signed(lp) : $signed(lp);
      right_q    <= b5_neg_q ? -$signed(rp) : $signed(rp);
    end
  end

endmodule

[src/joystick_differential_drive_mixer_top.sv]
// ----------------------------------------------------------------------------
// joystick_differential_drive_mixer_top
// joystick samples in, left and right wheel speeds in percent out
// ----------------------------------------------------------------------------
//  channel | dir | handshake                 | payload
//  in      | in  | in_valid_i / in_stall_o   | forward_sample_i, sideways_sample_i
//  out     | out | out_valid_o / out_stall_i | left_speed_o, right_speed_o
//  cfg     | in  | cfg_we_i                  | cfg_addr_i, cfg_wdata_i
//
//  one item per cycle while no stall holds the flow; a result passes the
//  front stages, the queue, one vectoring stage per step and six back stages.
//  reset clears all valid bits and the queue; no clearing pass is needed.
//  out_stall_i freezes the cordic and back stages; the four-entry queue keeps the
//  front taking items until it fills, then in_stall_o rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module joystick_differential_drive_mixer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [jddm_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [jddm_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [15:0]                forward_sample_i,
  input  logic signed [15:0]                sideways_sample_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [7:0]                 left_speed_o,
  output logic signed [7:0]                 right_speed_o
);

  logic [14:0] forward_center_q, sideways_center_q;
  logic [6:0]  deadzone_q, reverse_sideways_q;
  logic [7:0]  equalize_q;

  logic                                push, pop, adv;
  jddm_pkg::item_t                     front_item, head_item, cordic_item;
  jddm_pkg::q_status_t                 q_status;
  logic                                cordic_valid;
  logic signed [jddm_pkg::CX_W-1:0]    cordic_cx;
  logic signed [jddm_pkg::Z_W-1:0]     cordic_z;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      forward_center_q   <= 15'd12900;
      sideways_center_q  <= 15'd12800;
      deadzone_q         <= 7'd30;
      equalize_q         <= 8'd30;
      reverse_sideways_q <= 7'd65;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        jddm_pkg::CFG_FORWARD_CENTER:   forward_center_q   <= cfg_wdata_i;
        jddm_pkg::CFG_SIDEWAYS_CENTER:  sideways_center_q  <= cfg_wdata_i;
        jddm_pkg::CFG_DEADZONE:         deadzone_q         <= cfg_wdata_i[6:0];
        jddm_pkg::CFG_EQUALIZE:         equalize_q         <= cfg_wdata_i[7:0];
        jddm_pkg::CFG_REVERSE_SIDEWAYS: reverse_sideways_q <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // front: normalise and classify
  jddm_front u_front (
    .clk_i                      (clk_i),
    .rst_ni                     (rst_ni),
    .in_valid_i                 (in_valid_i),
    .in_stall_o                 (in_stall_o),
    .forward_sample_i           (forward_sample_i),
    .sideways_sample_i          (sideways_sample_i),
    .forward_center_i           (forward_center_q),
    .sideways_center_i          (sideways_center_q),
    .reverse_sideways_percent_i (reverse_sideways_q),
    .q_status_i                 (q_status),
    .push_o                     (push),
    .item_o                     (front_item)
  );

  // queue between the two halves
  assign pop = adv && !q_status.empty;

  jddm_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (front_item),
    .pop_i    (pop),
    .item_o   (head_item),
    .status_o (q_status)
  );

  // magnitude and angle
  jddm_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (!q_status.empty),
    .item_i  (head_item),
    .valid_o (cordic_valid),
    .item_o  (cordic_item),
    .cx_o    (cordic_cx),
    .z_o     (cordic_z)
  );

  // back: wheel mixing and output register
  jddm_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (cordic_valid),
    .item_i             (cordic_item),
    .cx_i               (cordic_cx),
    .z_i                (cordic_z),
    .deadzone_percent_i (deadzone_q),
    .equalize_percent_i (equalize_q),
    .adv_o              (adv),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .left_speed_o       (left_speed_o),
    .right_speed_o      (right_speed_o)
  );

endmodule

[src/jddm_checker.sv]
// ----------------------------------------------------------------------------
// jddm_checker
// port-level checks on the result channel of the drive mixer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "joystick_differential_drive_mixer_top_macros.svh"

module jddm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic signed [7:0] left_speed_o,
  input logic signed [7:0] right_speed_o
);

  logic        out_held;
  logic [15:0] speeds;
  logic        left_ok, right_ok, opposed;

  // result channel views
  assign out_held = out_valid_o && out_stall_i;
  assign speeds   = {left_speed_o, right_speed_o};
  assign left_ok  = (left_speed_o >= -8'sd100) && (left_speed_o <= 8'sd100);
  assign right_ok = (right_speed_o >= -8'sd100) && (right_speed_o <= 8'sd100);
  assign opposed  = ((left_speed_o < 8'sd0) && (right_speed_o > 8'sd0))
                 || ((left_speed_o > 8'sd0) && (right_speed_o < 8'sd0));

  // a held result keeps its speeds
  `JDDM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(speeds), "held")

  // speeds stay within full scale
  `JDDM_ASSERT_IMPLIES(a_speed_range, clk_i, rst_ni, out_valid_o, left_ok && right_ok, "range")

  // wheels never turn against each other
  `JDDM_ASSERT_IMPLIES(a_same_sign, clk_i, rst_ni, out_valid_o, !opposed, "wheels opposed")

endmodule

bind joystick_differential_drive_mixer_top jddm_checker u_jddm_checker (.*);

[tb/sv/tb_joystick_differential_drive_mixer_top.sv]
// ----------------------------------------------------------------------------
// tb_joystick_differential_drive_mixer_top
// self-checking bench for the joystick to wheel speed mixer. A directed table
// covers the stick extremes and register corner cases. Random sample pairs
// follow under several register settings. Each result is checked against its
// typed speeds or a bit-accurate predictor; both stream sides stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_joystick_differential_drive_mixer_top;

  localparam int RESULT_LATENCY  = jddm_pkg::CORDIC_N + 11;
  localparam int QUIET_LIMIT     = 5000;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int PHASES          = 6;
  localparam int HOLD_CYCLES     = 120;
  localparam int PLAN_ROWS       = 26;

  // register index that decodes to nothing
  localparam logic [jddm_pkg::CFG_ADDR_W-1:0] CFG_NO_REG = 3'd7;

  // atan(2^-i) as a fraction of a quarter turn, Q16
  localparam int QUARTER_ATAN [0:23] = '{
    32768, 19344, 10221, 5188, 2604, 1303, 652, 326,
    163, 81, 41, 20, 10, 5, 3, 1,
    1, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct packed {
    logic signed [7:0] left_pct;
    logic signed [7:0] right_pct;
  } speed_pair_t;

  typedef struct {
    logic [14:0] fwd_c;
    logic [14:0] side_c;
    logic [6:0]  dz;
    logic [7:0]  eq;
    logic [6:0]  rev;
  } mixer_setting_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [15:0]       a;       // forward sample or register index
    logic [15:0]       b;       // sideways sample or write data
    bit                typed;   // expected speeds given in the row
    logic signed [7:0] l;
    logic signed [7:0] r;
  } row_t;

  logic                            clk_i;
  logic                            rst_ni            = 1'b0;
  logic                            cfg_we_i          = 1'b0;
  logic [jddm_pkg::CFG_ADDR_W-1:0] cfg_addr_i        = '0;
  logic [jddm_pkg::CFG_W-1:0]      cfg_wdata_i       = '0;
  logic                            in_valid_i        = 1'b0;
  logic                            in_stall_o;
  logic signed [15:0]              forward_sample_i  = '0;
  logic signed [15:0]              sideways_sample_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i       = 1'b0;
  logic signed [7:0]               left_speed_o;
  logic signed [7:0]               right_speed_o;

  speed_pair_t    speeds_due [$];
  mixer_setting_t setting;
  row_t           plan [PLAN_ROWS];
  int             mismatches    = 0;
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;
  bit             hold_req      = 1'b0;

  joystick_differential_drive_mixer_top u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_addr_i        (cfg_addr_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .forward_sample_i  (forward_sample_i),
    .sideways_sample_i (sideways_sample_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .left_speed_o      (left_speed_o),
    .right_speed_o     (right_speed_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // centred reading to Q15 axis value, rounded half away from zero, saturated
  function automatic longint scale_axis(input longint d);
    longint q;
    q = ((d < 0 ? -d : d) * 65536 + jddm_pkg::FULL_SCALE) / (2 * jddm_pkg::FULL_SCALE);
    if (q > 32768) q = 32768;
    return (d < 0) ? -q : q;
  endfunction

  // Q31 wheel value to rounded percent
  function automatic logic signed [7:0] wheel_percent(input longint v);
    longint p;
    p = ((v < 0 ? -v : v) * 100 + (longint'(1) << 30)) >>> 31;
    if (v < 0) p = -p;
    return p[7:0];
  endfunction

  // wheel speeds for one sample pair under the current register setting
  function automatic speed_pair_t predict_speeds(input logic signed [15:0] fwd,
                                                 input logic signed [15:0] side);
    longint y, x, ax, ay, lw, rw, cx, cy, z, dx, dy, mag, inner, dir;
    longint outer_v, inner_v, dz_lim, eq_lim;
    speed_pair_t res;
    y  = scale_axis(longint'(fwd) - longint'(setting.fwd_c));
    x  = scale_axis(longint'(side) - longint'(setting.side_c));
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    if (ax * 100 < longint'(setting.rev) * 32768 && y < 0) begin
      // straight reverse
      lw = y * 65536;
      rw = lw;
    end else begin
      // vectoring rotation for magnitude and angle off the forward axis
      cx = ay * 256;
      cy = ax * 256;
      z  = 0;
      for (int i = 0; i < jddm_pkg::CORDIC_N; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx += dx;
          cy -= dy;
          z  += QUARTER_ATAN[i];
        end else begin
          cx -= dx;
          cy += dy;
          z  -= QUARTER_ATAN[i];
        end
      end
      if (z < 0) z = 0;
      if (z > 65536) z = 65536;
      if (cx < 0) cx = 0;
      mag = (cx * 39797 + (longint'(1) << 23)) >>> 24;
      if (mag > 32768) mag = 32768;
      // sideways with the stick level or back pivots on the inner wheel
      inner   = (x != 0 && y <= 0) ? 0 : 65536 - z;
      dir     = (x != 0) ? 1 : ((y >= 0) ? 1 : -1);
      outer_v = mag * 65536 * dir;
      inner_v = mag * inner * dir;
      lw      = (x >= 0) ? inner_v : outer_v;
      rw      = (x >= 0) ? outer_v : inner_v;
    end
    // deadzone, then equalise close speeds of one sign
    dz_lim = longint'(setting.dz) << 31;
    eq_lim = longint'(setting.eq) << 31;
    if ((lw < 0 ? -lw : lw) * 100 < dz_lim && (rw < 0 ? -rw : rw) * 100 < dz_lim) begin
      lw = 0;
      rw = 0;
    end else if (((lw - rw) < 0 ? rw - lw : lw - rw) * 100 < eq_lim) begin
      if (lw > 0 && rw > 0) begin
        if (lw < rw) lw = rw; else rw = lw;
      end else if (lw < 0 && rw < 0) begin
        if (lw > rw) lw = rw; else rw = lw;
      end
    end
    res.left_pct  = wheel_percent(lw);
    res.right_pct = wheel_percent(rw);
    return res;
  endfunction

  // random reading around a centre, clipped to the sample range
  function automatic logic [15:0] near_centre(input logic [14:0] centre_val, input int span);
    int v;
    v = int'(centre_val) + int'($urandom_range(2 * span)) - span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // register write, mirrored into the predictor's copy
  task automatic cfg_write(input logic [jddm_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [jddm_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      jddm_pkg::CFG_FORWARD_CENTER:   setting.fwd_c  = val[14:0];
      jddm_pkg::CFG_SIDEWAYS_CENTER:  setting.side_c = val[14:0];
      jddm_pkg::CFG_DEADZONE:         setting.dz     = val[6:0];
      jddm_pkg::CFG_EQUALIZE:         setting.eq     = val[7:0];
      jddm_pkg::CFG_REVERSE_SIDEWAYS: setting.rev    = val[6:0];
      default: ;
    endcase
  endtask

  // one input transfer; valid stays high on return
  task automatic put_sample(input logic [15:0] fwd, input logic [15:0] side,
                            input bit typed, input speed_pair_t typed_val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    forward_sample_i  <= fwd;
    sideways_sample_i <= side;
    do @(posedge clk_i); while (in_stall_o);
    speeds_due.push_back(typed ? typed_val : predict_speeds(fwd, side));
  endtask

  // stop offering and wait for every pending result
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (speeds_due.size() != 0);
  endtask

  // result checking and receiver stalls
  initial begin : result_check
    speed_pair_t due;
    int          hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (speeds_due.size() == 0) begin
          $display("%0t: unexpected result left %0d right %0d",
                   $time, left_speed_o, right_speed_o);
          mismatches++;
        end else begin
          due = speeds_due.pop_front();
          if (left_speed_o !== due.left_pct) begin
            $display("%0t: left_speed expected %0d got %0d",
                     $time, due.left_pct, left_speed_o);
            mismatches++;
          end
          if (right_speed_o !== due.right_pct) begin
            $display("%0t: right_speed expected %0d got %0d",
                     $time, due.right_pct, right_speed_o);
            mismatches++;
          end
        end
      end
      // long hold-off so the pipeline fills and backs up
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) hold_left--;
      out_stall_i <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog on cycles without any transfer
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("joystick_differential_drive_mixer_top: mismatch");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    mixer_setting_t target;
    speed_pair_t    typed_val;
    logic [15:0]    fwd, side;
    int             sel, span;

    setting = '{15'd12900, 15'd12800, 7'd30, 8'd30, 7'd65};

    // directed rows, reset setting first: centres at 12900 and 12800
    plan = '{
      '{ROW_SAMPLE, 16'd12900, 16'd12800, 1'b1, 8'sd0, 8'sd0},       // centred
      '{ROW_SAMPLE, 16'd25900, 16'd12800, 1'b1, 8'sd100, 8'sd100},   // full forward
      '{ROW_SAMPLE, -16'sd100, 16'd12800, 1'b1, -8'sd100, -8'sd100}, // full reverse
      '{ROW_SAMPLE, 16'd12900, 16'd25800, 1'b1, 8'sd0, 8'sd100},     // full right
      '{ROW_SAMPLE, 16'd12900, -16'sd200, 1'b1, 8'sd100, 8'sd0},     // full left
      '{ROW_SAMPLE, 16'h7fff, 16'h7fff, 1'b0, 8'sd0, 8'sd0},
      '{ROW_SAMPLE, 16'h8000, 16'h8000, 1'b0, 8'sd0, 8'sd0},
      '{ROW_SAMPLE, 16'h7fff, 16'h8000, 1'b0, 8'sd0, 8'sd0},
      '{ROW_SAMPLE, 16'h8000, 16'h7fff, 1'b0, 8'sd0, 8'sd0},
      '{ROW_SAMPLE, 16'hffff, 16'hffff, 1'b0, 8'sd0, 8'sd0},
      '{ROW_SAMPLE, 16'h5555, 16'haaaa, 1'b0, 8'sd0, 8'sd0},
      '{ROW_SAMPLE, 16'd13900, 16'd13800, 1'b0, 8'sd0, 8'sd0},      // inside deadzone
      '{ROW_SAMPLE, 16'd21900, 16'd21800, 1'b0, 8'sd0, 8'sd0},      // forward diagonal
      '{ROW_SAMPLE, 16'd3900, 16'd24800, 1'b0, 8'sd0, 8'sd0},       // back and sideways
      '{ROW_SAMPLE, 16'd900, 16'd15800, 1'b0, 8'sd0, 8'sd0},        // back, slight side
      '{ROW_SAMPLE, 16'd25900, 16'd14800, 1'b0, 8'sd0, 8'sd0},      // forward, slight side
      // write to an index with no register behind it
      '{ROW_WRITE, 16'(CFG_NO_REG), 16'd0, 1'b0, 8'sd0, 8'sd0},
      '{ROW_SAMPLE, 16'd12900, 16'd12800, 1'b1, 8'sd0, 8'sd0},
      // zero reverse threshold, centres at zero: pure reverse goes through the mix
      '{ROW_WRITE, 16'(jddm_pkg::CFG_REVERSE_SIDEWAYS), 16'd0, 1'b0, 8'sd0, 8'sd0},
      '{ROW_WRITE, 16'(jddm_pkg::CFG_FORWARD_CENTER), 16'd0, 1'b0, 8'sd0, 8'sd0},
      '{ROW_WRITE, 16'(jddm_pkg::CFG_SIDEWAYS_CENTER), 16'd0, 1'b0, 8'sd0, 8'sd0},
      '{ROW_SAMPLE, -16'sd13000, 16'd0, 1'b1, -8'sd100, -8'sd100},
      // over-wide write keeps 127: every backward stick is straight reverse
      '{ROW_WRITE, 16'(jddm_pkg::CFG_REVERSE_SIDEWAYS), 16'h7fff, 1'b0, 8'sd0, 8'sd0},
      '{ROW_SAMPLE, -16'sd13000, 16'd13000, 1'b1, -8'sd100, -8'sd100},
      // deadzone of 127 swallows even full deflection
      '{ROW_WRITE, 16'(jddm_pkg::CFG_DEADZONE), 16'h7fff, 1'b0, 8'sd0, 8'sd0},
      '{ROW_SAMPLE, 16'd13000, 16'd0, 1'b1, 8'sd0, 8'sd0}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 34;
    recv_idle_pct = 74;
    @(posedge clk_i);

    // directed part
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        wait_drained();
        cfg_write(plan[i].a[jddm_pkg::CFG_ADDR_W-1:0], plan[i].b[jddm_pkg::CFG_W-1:0]);
      end else begin
        typed_val.left_pct  = plan[i].l;
        typed_val.right_pct = plan[i].r;
        put_sample(plan[i].a, plan[i].b, plan[i].typed, typed_val);
      end
    end

    // random part, one register setting per phase
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      case (phase)
        0: target = '{15'd12900, 15'd12800, 7'd30, 8'd30, 7'd65};
        1: target = '{15'd0, 15'd0, 7'd0, 8'd0, 7'd0};
        2: target = '{15'd32767, 15'd32767, 7'd100, 8'd200, 7'd100};
        4: target = '{15'd16384, 15'd16384, 7'd10, 8'd50, 7'd80};
        default: begin
          target.fwd_c  = 15'($urandom_range(32767));
          target.side_c = 15'($urandom_range(32767));
          target.dz     = 7'($urandom_range(127));
          target.eq     = 8'($urandom_range(255));
          target.rev    = 7'($urandom_range(127));
        end
      endcase
      cfg_write(jddm_pkg::CFG_FORWARD_CENTER, target.fwd_c);
      cfg_write(jddm_pkg::CFG_SIDEWAYS_CENTER, target.side_c);
      cfg_write(jddm_pkg::CFG_DEADZONE, jddm_pkg::CFG_W'(target.dz));
      cfg_write(jddm_pkg::CFG_EQUALIZE, jddm_pkg::CFG_W'(target.eq));
      cfg_write(jddm_pkg::CFG_REVERSE_SIDEWAYS, jddm_pkg::CFG_W'(target.rev));

      // receiver-heavy idling, then sender-heavy, then none
      if (phase < 2) begin
        send_idle_pct = 34;
        recv_idle_pct = 74;
      end else if (phase < 4) begin
        send_idle_pct = 74;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (phase == 4) hold_req = 1'b1;

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        sel = $urandom_range(99);
        if (sel < 12) begin
          // raw noise over the whole sample range
          fwd  = 16'($urandom);
          side = 16'($urandom);
        end else begin
          span = (sel < 30) ? 2500 : 16000;
          fwd  = near_centre(setting.fwd_c, span);
          side = near_centre(setting.side_c, span);
          // exactly centred axes now and then
          sel = $urandom_range(9);
          if (sel == 0) side = {1'b0, setting.side_c};
          else if (sel == 1) fwd = {1'b0, setting.fwd_c};
        end
        put_sample(fwd, side, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (RESULT_LATENCY + 4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("joystick_differential_drive_mixer_top: match");
    end else begin
      $display("joystick_differential_drive_mixer_top: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/jddm_pkg.sv
src/jddm_front.sv
src/jddm_queue.sv
src/jddm_cordic.sv
src/jddm_back.sv
src/joystick_differential_drive_mixer_top.sv
src/jddm_checker.sv
tb/sv/tb_joystick_differential_drive_mixer_top.sv
